FILE: hw/rtl/phs_pkg.sv
// Shared constants, a side-payload type and a helper function for the Phong specular shader.
// Used by phs_pow, phong_specular_shade and the testbench; depends on nothing else.
package phs_pkg;

  // Latencies in register stages, counted from the stage that feeds each unit.
  localparam int UNIT_LAT = 69;
  localparam int POW_LAT  = 36;

  // Stage numbers of the top-level pipeline; stage 0 holds the difference vectors.
  localparam int ST_U   = UNIT_LAT;
  localparam int ST_X   = ST_U + 6;
  localparam int ST_F   = ST_X + POW_LAT;
  localparam int ST_OUT = ST_F + 3;
  localparam int NSTAGE = ST_OUT + 1;

  localparam int XW = 34;

  localparam logic [30:0] ONE30 = 31'h4000_0000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CAM_X       = 3'd0;
  localparam logic [2:0] CFG_CAM_Y       = 3'd1;
  localparam logic [2:0] CFG_CAM_Z       = 3'd2;
  localparam logic [2:0] CFG_LIGHT_X     = 3'd3;
  localparam logic [2:0] CFG_LIGHT_Y     = 3'd4;
  localparam logic [2:0] CFG_LIGHT_Z     = 3'd5;
  localparam logic [2:0] CFG_LIGHT_COLOR = 3'd6;
  localparam logic [2:0] CFG_LIGHT_RATIO = 3'd7;

  typedef struct packed {
    logic [2:0][15:0] nv;
    logic [31:0]      rs;
    logic [15:0]      shin;
  } side_t;

  // Root table of the exp2 unit: c0 = 2^31 and ck = floor(sqrt(c(k-1) * 2^30)).
  // Only ever called with constant arguments, so it folds away at elaboration.
  function automatic logic [31:0] exp2_root(int k);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      v = c << 30;
      r = '0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
    end
    return c[31:0];
  endfunction

endpackage

FILE: hw/rtl/phs_unit_dir.sv
// Pipelined unit-vector unit: magnitude, prescale, square sum, integer square root
// and per-component restoring division. Depends on nothing.
module phs_unit_dir (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [2:0][32:0] d_i,
  output logic [2:0][31:0] u_o
);

  logic [2:0][32:0] mag1_q;
  logic [2:0]       neg1_q;
  logic [2:0][32:0] mag2_q;
  logic [2:0]       neg2_q;
  logic [5:0]       top2_q;
  logic             zero2_q;
  logic [2:0][29:0] a3_q;
  logic [2:0]       neg3_q;
  logic             zero3_q;
  logic [2:0][59:0] sq4_q;
  logic [2:0][29:0] a4_q;
  logic [2:0]       neg4_q;
  logic             zero4_q;

  // Square root stages: index 0 holds the sum of squares.
  logic [62:0]      sv_q   [0:31];
  logic [62:0]      sr_q   [0:31];
  logic [2:0][29:0] sa_q   [0:31];
  logic [2:0]       sneg_q [0:31];
  logic             szero_q[0:31];

  // Division stages: index 0 holds the initial remainders.
  logic [2:0][30:0] dr_q   [0:31];
  logic [2:0][30:0] dq_q   [0:31];
  logic [30:0]      dlen_q [0:31];
  logic [2:0]       dneg_q [0:31];
  logic             dzero_q[0:31];
  logic [2:0]       dbit_q;

  logic [2:0][31:0] u_q;

  logic [32:0]      mag_or;
  logic [5:0]       top_d;
  logic [2:0][29:0] a3_d;

  always_comb begin
    mag_or = mag1_q[0] | mag1_q[1] | mag1_q[2];
    top_d  = '0;
    for (int i = 0; i < 33; i++) begin
      if (mag_or[i]) top_d = 6'(i);
    end
  end

  // The largest magnitude ends up with its top set bit at bit 29.
  always_comb begin
    logic [62:0] sh;
    for (int c = 0; c < 3; c++) begin
      if (top2_q > 6'd29) begin
        sh = {30'd0, mag2_q[c]} >> (top2_q - 6'd29);
      end else begin
        sh = {30'd0, mag2_q[c]} << (6'd29 - top2_q);
      end
      a3_d[c] = sh[29:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        neg1_q[c] <= d_i[c][32];
        mag1_q[c] <= d_i[c][32] ? (33'd0 - d_i[c]) : d_i[c];
      end
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      top2_q  <= top_d;
      zero2_q <= (mag_or == 33'd0);
      a3_q    <= a3_d;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
      for (int c = 0; c < 3; c++) begin
        sq4_q[c] <= a3_q[c] * a3_q[c];
      end
      a4_q    <= a3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // One result bit of the square root per stage.
  always_ff @(posedge clk_i) begin
    logic [62:0] bitv;
    logic [62:0] trial;
    if (en_i) begin
      sv_q[0]    <= {3'd0, sq4_q[0]} + {3'd0, sq4_q[1]} + {3'd0, sq4_q[2]};
      sr_q[0]    <= '0;
      sa_q[0]    <= a4_q;
      sneg_q[0]  <= neg4_q;
      szero_q[0] <= zero4_q;
      for (int k = 1; k <= 31; k++) begin
        bitv  = 63'd1 << (2 * (31 - k));
        trial = sr_q[k-1] + bitv;
        if (sv_q[k-1] >= trial) begin
          sv_q[k] <= sv_q[k-1] - trial;
          sr_q[k] <= (sr_q[k-1] >> 1) + bitv;
        end else begin
          sv_q[k] <= sv_q[k-1];
          sr_q[k] <= sr_q[k-1] >> 1;
        end
        sa_q[k]    <= sa_q[k-1];
        sneg_q[k]  <= sneg_q[k-1];
        szero_q[k] <= szero_q[k-1];
      end
    end
  end

  // Quotient bits 30 down to 0 of (a << 30) / len; the higher bits are known to be zero,
  // so the remainder starts from the dividend bits above them.
  always_ff @(posedge clk_i) begin
    logic [31:0] t;
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        dr_q[0][c] <= {2'd0, sa_q[31][c][29:1]};
        dbit_q[c]  <= sa_q[31][c][0];
      end
      dq_q[0]    <= '0;
      dlen_q[0]  <= sr_q[31][30:0];
      dneg_q[0]  <= sneg_q[31];
      dzero_q[0] <= szero_q[31];
      for (int k = 1; k <= 31; k++) begin
        for (int c = 0; c < 3; c++) begin
          t = {dr_q[k-1][c], (k == 1) ? dbit_q[c] : 1'b0};
          if (t >= {1'b0, dlen_q[k-1]}) begin
            dr_q[k][c] <= 31'(t - {1'b0, dlen_q[k-1]});
            dq_q[k][c] <= {dq_q[k-1][c][29:0], 1'b1};
          end else begin
            dr_q[k][c] <= t[30:0];
            dq_q[k][c] <= {dq_q[k-1][c][29:0], 1'b0};
          end
        end
        dlen_q[k]  <= dlen_q[k-1];
        dneg_q[k]  <= dneg_q[k-1];
        dzero_q[k] <= dzero_q[k-1];
      end
      for (int c = 0; c < 3; c++) begin
        if (dzero_q[31]) begin
          u_q[c] <= '0;
        end else if (dneg_q[31][c]) begin
          u_q[c] <= 32'd0 - {1'b0, dq_q[31][c]};
        end else begin
          u_q[c] <= {1'b0, dq_q[31][c]};
        end
      end
    end
  end

  assign u_o = u_q;

endmodule

FILE: hw/rtl/phs_pow.sv
// Pipelined power unit: factor = x^shininess as exp2(shininess * log2(x)), Q.30 out.
// Depends on phs_pkg for the exp2 root table, the x width and the constant one.
module phs_pow (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [phs_pkg::XW-1:0] x_i,
  input  logic [15:0]          shin_i,
  output logic [30:0]          factor_o
);

  logic        one1_q;
  logic        zero1_q;
  logic [23:0] x1_q;
  logic [4:0]  p1_q;
  logic [15:0] shin1_q;

  // Log stages: index 0 holds the mantissa in Q1.30.
  logic [30:0] lm_q   [0:16];
  logic [15:0] lf_q   [0:16];
  logic [4:0]  lp_q   [0:16];
  logic [15:0] lshin_q[0:16];
  logic        lone_q [0:16];
  logic        lzero_q[0:16];

  // Exp stages: index 0 holds the split exponent.
  logic [31:0] re_q   [0:16];
  logic [15:0] ef_q   [0:16];
  logic [14:0] eq_q   [0:16];
  logic        eone_q [0:16];
  logic        ezero_q[0:16];

  logic [30:0] factor_q;

  logic        nonpos;
  logic        big;
  logic [4:0]  p_d;

  always_comb begin
    nonpos = x_i[phs_pkg::XW-1] || (x_i == '0);
    big    = !x_i[phs_pkg::XW-1] && (|x_i[phs_pkg::XW-2:24]);
    p_d    = '0;
    for (int i = 0; i < 24; i++) begin
      if (x_i[i]) p_d = 5'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [53:0] msh;
    logic [61:0] sq;
    logic [31:0] t;
    if (en_i) begin
      one1_q  <= (shin_i == 16'd0) || big;
      zero1_q <= (shin_i != 16'd0) && nonpos;
      x1_q    <= x_i[23:0];
      p1_q    <= p_d;
      shin1_q <= shin_i;

      msh        = {30'd0, x1_q} << (5'd30 - p1_q);
      lm_q[0]    <= msh[30:0];
      lf_q[0]    <= '0;
      lp_q[0]    <= p1_q;
      lshin_q[0] <= shin1_q;
      lone_q[0]  <= one1_q;
      lzero_q[0] <= zero1_q;
      // Each squaring doubles the exponent; an overflow past 2.0 is the next bit.
      for (int k = 1; k <= 16; k++) begin
        sq = lm_q[k-1] * lm_q[k-1];
        t  = sq[61:30];
        if (t[31]) begin
          lm_q[k] <= t[31:1];
          lf_q[k] <= {lf_q[k-1][14:0], 1'b1};
        end else begin
          lm_q[k] <= t[30:0];
          lf_q[k] <= {lf_q[k-1][14:0], 1'b0};
        end
        lp_q[k]    <= lp_q[k-1];
        lshin_q[k] <= lshin_q[k-1];
        lone_q[k]  <= lone_q[k-1];
        lzero_q[k] <= lzero_q[k-1];
      end
    end
  end

  logic signed [21:0] lg;
  logic signed [38:0] ep;

  assign lg = $signed({6'(lp_q[16]) - 6'd24, lf_q[16]});
  assign ep = lg * $signed({1'b0, lshin_q[16]});

  always_ff @(posedge clk_i) begin
    logic [63:0] pr;
    if (en_i) begin
      re_q[0]    <= {2'd0, phs_pkg::ONE30[29:0]} | 32'h4000_0000;
      ef_q[0]    <= ep[23:8];
      eq_q[0]    <= ep[38:24];
      eone_q[0]  <= lone_q[16];
      ezero_q[0] <= lzero_q[16];
      for (int k = 1; k <= 16; k++) begin
        pr = re_q[k-1] * phs_pkg::exp2_root(k);
        if (ef_q[k-1][16-k]) begin
          re_q[k] <= pr[61:30];
        end else begin
          re_q[k] <= re_q[k-1];
        end
        ef_q[k]    <= ef_q[k-1];
        eq_q[k]    <= eq_q[k-1];
        eone_q[k]  <= eone_q[k-1];
        ezero_q[k] <= ezero_q[k-1];
      end
    end
  end

  // Unless forced, the integer exponent is negative: a right shift of the root product.
  logic [15:0] nq;
  logic [31:0] rsh;
  logic [30:0] factor_d;

  always_comb begin
    nq  = 16'd0 - {eq_q[16][14], eq_q[16]};
    rsh = (nq >= 16'd31) ? 32'd0 : (re_q[16] >> nq[4:0]);
    if (eone_q[16]) begin
      factor_d = phs_pkg::ONE30;
    end else if (ezero_q[16]) begin
      factor_d = '0;
    end else if (rsh > {1'b0, phs_pkg::ONE30}) begin
      factor_d = phs_pkg::ONE30;
    end else begin
      factor_d = rsh[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      factor_q <= factor_d;
    end
  end

  assign factor_o = factor_q;

endmodule

FILE: hw/rtl/phong_specular_shade.sv
// Top level of the Phong specular shader: configuration registers, direction and
// reflection math, intensity and color scaling. Uses phs_pkg, phs_unit_dir, phs_pow.
//
//   Channel   Direction  Handshake                 Payload
//   in        in         in_valid_i / in_stall_o   point, normal, spec_coeff, shininess
//   out       out        out_valid_o / out_stall_i spec_rgb_o
//   config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One item enters per cycle while the pipeline is not held; its depth is set mostly
// by the one-bit-per-stage square root and division of the direction units.
// Reset clears the valid bits and loads the register reset values; data stages keep junk.
// The whole pipeline advances together; it holds only while a result waits on a stall.
module phong_specular_shade (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [15:0] normal_x_i,
  input  logic [15:0] normal_y_i,
  input  logic [15:0] normal_z_i,
  input  logic [15:0] spec_coeff_i,
  input  logic [15:0] shininess_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] spec_rgb_o
);

  logic [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [31:0] light_x_q, light_y_q, light_z_q;
  logic [23:0] light_color_q;
  logic [15:0] light_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q       <= '0;
      cam_y_q       <= '0;
      cam_z_q       <= '0;
      light_x_q     <= '0;
      light_y_q     <= '0;
      light_z_q     <= '0;
      light_color_q <= 24'hFF_FFFF;
      light_ratio_q <= 16'h8000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        phs_pkg::CFG_CAM_X:       cam_x_q       <= cfg_wdata_i;
        phs_pkg::CFG_CAM_Y:       cam_y_q       <= cfg_wdata_i;
        phs_pkg::CFG_CAM_Z:       cam_z_q       <= cfg_wdata_i;
        phs_pkg::CFG_LIGHT_X:     light_x_q     <= cfg_wdata_i;
        phs_pkg::CFG_LIGHT_Y:     light_y_q     <= cfg_wdata_i;
        phs_pkg::CFG_LIGHT_Z:     light_z_q     <= cfg_wdata_i;
        phs_pkg::CFG_LIGHT_COLOR: light_color_q <= cfg_wdata_i[23:0];
        phs_pkg::CFG_LIGHT_RATIO: light_ratio_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic                        en;
  logic                        in_accept;
  logic [phs_pkg::NSTAGE-1:0]  v_q;

  assign en         = !(v_q[phs_pkg::ST_OUT] && out_stall_i);
  assign in_stall_o = !en;
  assign in_accept  = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[phs_pkg::NSTAGE-2:0], in_valid_i};
    end
  end

  // Stage 0: difference vectors and side payload.
  logic [2:0][32:0]    dl_q, dv_q;
  phs_pkg::side_t      side_q [0:phs_pkg::ST_U];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= {light_x_q[31], light_x_q} - {point_x_i[31], point_x_i};
      dl_q[1] <= {light_y_q[31], light_y_q} - {point_y_i[31], point_y_i};
      dl_q[2] <= {light_z_q[31], light_z_q} - {point_z_i[31], point_z_i};
      dv_q[0] <= {cam_x_q[31], cam_x_q} - {point_x_i[31], point_x_i};
      dv_q[1] <= {cam_y_q[31], cam_y_q} - {point_y_i[31], point_y_i};
      dv_q[2] <= {cam_z_q[31], cam_z_q} - {point_z_i[31], point_z_i};
      side_q[0].nv   <= {normal_z_i, normal_y_i, normal_x_i};
      side_q[0].rs   <= light_ratio_q * spec_coeff_i;
      side_q[0].shin <= shininess_i;
      for (int i = 1; i <= phs_pkg::ST_U; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic [2:0][31:0] lu, vu;

  phs_unit_dir u_light_dir (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dl_q),
    .u_o   (lu)
  );

  phs_unit_dir u_view_dir (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dv_q),
    .u_o   (vu)
  );

  logic [2:0][47:0] pa_ta_q;
  logic [2:0][31:0] lu_ta_q, vu_ta_q, vu_tb_q, vu_tc_q, vu_td_q;
  logic [2:0][15:0] nv_ta_q, nv_tb_q;
  logic [31:0]      rs_ta_q, rs_tb_q, rs_tc_q, rs_td_q, rs_te_q;
  logic [15:0]      shin_ta_q, shin_tb_q, shin_tc_q, shin_td_q, shin_te_q, shin_tf_q;
  logic [35:0]      ln_tb_q;
  logic [2:0][31:0] lu_tb_q;
  logic [2:0][32:0] th_tc_q;
  logic [2:0][25:0] lsh_tc_q;
  logic [2:0][31:0] rr_td_q;
  logic [2:0][63:0] vr_te_q;
  logic [phs_pkg::XW-1:0] x_tf_q;
  logic [31:0]      rs_pipe_q [0:phs_pkg::POW_LAT];

  logic signed [49:0] ln_sum;
  logic signed [65:0] x_sum;
  logic [2:0][47:0]   pa_d;
  logic [2:0][51:0]   t_d;
  logic [2:0][33:0]   rr_d;
  logic [2:0][63:0]   vr_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pa_d[c] = $signed(lu[c]) * $signed(side_q[phs_pkg::ST_U].nv[c]);
      t_d[c]  = $signed(ln_tb_q) * $signed(nv_tb_q[c]);
      rr_d[c] = $signed(th_tc_q[c]) - $signed(lsh_tc_q[c]);
      vr_d[c] = $signed(vu_td_q[c]) * $signed(rr_td_q[c]);
    end
    ln_sum = $signed(pa_ta_q[0]) + $signed(pa_ta_q[1]) + $signed(pa_ta_q[2]);
    x_sum  = $signed(vr_te_q[0]) + $signed(vr_te_q[1]) + $signed(vr_te_q[2]);
  end

  // Reflection R = 2(L.N)N - L and x = V.R, with every scaling a floor shift.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_ta_q   <= pa_d;
      lu_ta_q   <= lu;
      vu_ta_q   <= vu;
      nv_ta_q   <= side_q[phs_pkg::ST_U].nv;
      rs_ta_q   <= side_q[phs_pkg::ST_U].rs;
      shin_ta_q <= side_q[phs_pkg::ST_U].shin;

      ln_tb_q   <= ln_sum[49:14];
      lu_tb_q   <= lu_ta_q;
      vu_tb_q   <= vu_ta_q;
      nv_tb_q   <= nv_ta_q;
      rs_tb_q   <= rs_ta_q;
      shin_tb_q <= shin_ta_q;

      for (int c = 0; c < 3; c++) begin
        th_tc_q[c]  <= t_d[c][51:19];
        lsh_tc_q[c] <= lu_tb_q[c][31:6];
      end
      vu_tc_q   <= vu_tb_q;
      rs_tc_q   <= rs_tb_q;
      shin_tc_q <= shin_tb_q;

      for (int c = 0; c < 3; c++) begin
        rr_td_q[c] <= rr_d[c][31:0];
      end
      vu_td_q   <= vu_tc_q;
      rs_td_q   <= rs_tc_q;
      shin_td_q <= shin_tc_q;

      vr_te_q   <= vr_d;
      rs_te_q   <= rs_td_q;
      shin_te_q <= shin_td_q;

      x_tf_q       <= x_sum[63:30];
      shin_tf_q    <= shin_te_q;
      rs_pipe_q[0] <= rs_te_q;
      for (int i = 1; i <= phs_pkg::POW_LAT; i++) begin
        rs_pipe_q[i] <= rs_pipe_q[i-1];
      end
    end
  end

  logic [30:0] factor;

  phs_pow u_pow (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (x_tf_q),
    .shin_i   (shin_tf_q),
    .factor_o (factor)
  );

  logic [62:0]      prod_q;
  logic [30:0]      inten_q;
  logic [23:0]      spec_rgb_q;
  logic [62:0]      prod_d;
  logic [2:0][38:0] ch_d;

  always_comb begin
    prod_d = rs_pipe_q[phs_pkg::POW_LAT] * factor;
    for (int c = 0; c < 3; c++) begin
      ch_d[c] = inten_q * light_color_q[8*c +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      if (prod_q[62:30] > {2'd0, phs_pkg::ONE30}) begin
        inten_q <= phs_pkg::ONE30;
      end else begin
        inten_q <= prod_q[60:30];
      end
      spec_rgb_q <= {ch_d[2][37:30], ch_d[1][37:30], ch_d[0][37:30]};
    end
  end

  assign out_valid_o = v_q[phs_pkg::ST_OUT];
  assign spec_rgb_o  = spec_rgb_q;

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved while the output was stalled");

  a_no_invented_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !in_accept) |=> ($countones(v_q) <= $past($countones(v_q))))
    else $error("item count grew without an input transfer");

  a_factor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[phs_pkg::ST_F] |-> (factor <= phs_pkg::ONE30))
    else $error("specular factor above one");

  a_inten_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[phs_pkg::ST_F + 2] |-> (inten_q <= phs_pkg::ONE30))
    else $error("intensity above one");

endmodule

FILE: tb/tb_phong_specular_shade.sv
// Self-checking testbench for phong_specular_shade: drives surface hits and compares
// each packed specular color against a bit-exact fixed-point predictor. Uses phs_pkg.
`timescale 1ns / 100ps

module tb_phong_specular_shade;

  localparam longint ONE_Q30 = 64'sd1 << 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] pt_x = '0, pt_y = '0, pt_z = '0;
  logic [15:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
  logic [15:0] spec = '0, shin = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] rgb;

  // Shadow copy of the configuration registers.
  logic [31:0] cam_q [3];
  logic [31:0] lpos_q [3];
  logic [23:0] lcolor_q;
  logic [15:0] lratio_q;

  logic [23:0] rgb_expected [$];
  int          n_err = 0;
  int          n_checked = 0;
  int          n_sent = 0;

  phong_specular_shade dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(pt_x), .point_y_i(pt_y), .point_z_i(pt_z),
    .normal_x_i(nrm_x), .normal_y_i(nrm_y), .normal_z_i(nrm_z),
    .spec_coeff_i(spec), .shininess_i(shin),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .spec_rgb_o(rgb)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int msb_pos(longint unsigned v);
    int p;
    p = -1;
    while (v != 0) begin
      v >>= 1;
      p++;
    end
    return p;
  endfunction

  // Normalizes a difference vector to Q1.30; a zero vector stays zero.
  task automatic normalize(input longint d[3], output longint u[3]);
    longint unsigned a[3], mx, ss, len;
    int b;
    mx = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = d[i] < 0 ? -d[i] : d[i];
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return;
    end
    b = msb_pos(mx);
    for (int i = 0; i < 3; i++) begin
      if (b > 29) a[i] >>= (b - 29);
      else a[i] <<= (29 - b);
      ss += a[i] * a[i];
    end
    len = isqrt(ss);
    for (int i = 0; i < 3; i++) begin
      longint q;
      q = longint'((a[i] << 30) / len);
      u[i] = d[i] < 0 ? -q : q;
    end
  endtask

  // Raises x (Q.24) to the Q8.8 exponent with the iterative log2 and exp2.
  function automatic longint spec_power(longint x, logic [15:0] ex);
    longint unsigned m, c, r;
    longint lg, e, q, f;
    int p;
    int unsigned frac;
    frac = 0;
    if (ex == 0) return ONE_Q30;
    if (x <= 0) return 0;
    if (x >= (64'sd1 << 24)) return ONE_Q30;
    p = msb_pos(x);
    m = longint'(x) << (30 - p);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    lg = longint'(p - 24) * 65536 + longint'(frac);
    e = floor_sh(lg * longint'(ex), 8);
    q = floor_sh(e, 16);
    f = e - q * 65536;
    c = 64'd1 << 31;
    r = ONE_Q30;
    for (int k = 1; k <= 16; k++) begin
      c = isqrt(c << 30);
      if ((f >> (16 - k)) & 1) r = (r * c) >> 30;
    end
    if (-q >= 31) return 0;
    r >>= -q;
    if (r > ONE_Q30) r = ONE_Q30;
    return longint'(r);
  endfunction

  task automatic shade_color(input logic [31:0] p[3], input logic [15:0] n[3],
                             input logic [15:0] sc, input logic [15:0] sh,
                             output logic [23:0] col);
    longint dl[3], dv[3], lu[3], vu[3], rv[3], nv[3];
    longint ln, x, fac;
    longint unsigned prod, inten, ch;
    ln = 0;
    x = 0;
    for (int i = 0; i < 3; i++) begin
      nv[i] = longint'($signed(n[i]));
      dl[i] = longint'($signed(lpos_q[i])) - longint'($signed(p[i]));
      dv[i] = longint'($signed(cam_q[i])) - longint'($signed(p[i]));
    end
    normalize(dl, lu);
    normalize(dv, vu);
    for (int i = 0; i < 3; i++) ln += lu[i] * nv[i];
    ln = floor_sh(ln, 14);
    for (int i = 0; i < 3; i++)
      rv[i] = floor_sh(2 * ln * nv[i], 20) - floor_sh(lu[i], 6);
    for (int i = 0; i < 3; i++) x += vu[i] * rv[i];
    x = floor_sh(x, 30);
    fac = spec_power(x, sh);
    prod = (longint'(lratio_q) * longint'(sc) * fac) >> 30;
    inten = prod > ONE_Q30 ? ONE_Q30 : prod;
    for (int i = 0; i < 3; i++) begin
      ch = (inten * lcolor_q[23 - 8*i -: 8]) >> 30;
      col[23 - 8*i -: 8] = ch[7:0];
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      phs_pkg::CFG_CAM_X, phs_pkg::CFG_CAM_Y, phs_pkg::CFG_CAM_Z: cam_q[idx] = val;
      phs_pkg::CFG_LIGHT_X, phs_pkg::CFG_LIGHT_Y, phs_pkg::CFG_LIGHT_Z:
        lpos_q[idx - phs_pkg::CFG_LIGHT_X] = val;
      phs_pkg::CFG_LIGHT_COLOR: lcolor_q = val[23:0];
      phs_pkg::CFG_LIGHT_RATIO: lratio_q = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits for the pipeline to drain before any register write.
  task automatic drain();
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic send_hit(input logic [31:0] p[3], input logic [15:0] n[3],
                          input logic [15:0] sc, input logic [15:0] sh, input bit gaps);
    logic [23:0] col;
    if (gaps) begin
      int g;
      g = $urandom_range(0, 15);
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    pt_x <= p[0]; pt_y <= p[1]; pt_z <= p[2];
    nrm_x <= n[0]; nrm_y <= n[1]; nrm_z <= n[2];
    spec <= sc;
    shin <= sh;
    shade_color(p, n, sc, sh, col);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rgb_expected.push_back(col);
    n_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  // Random unit-ish normal in Q2.14 with an occasional raw value.
  task automatic rand_normal(output logic [15:0] n[3]);
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < 3; i++) n[i] = 16'($urandom());
    end else begin
      int ax;
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++)
        n[i] = (i == ax) ? ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                         : 16'($signed($urandom_range(0, 12000)) - 6000);
    end
  endtask

  task automatic test_directed();
    logic [31:0] p[3];
    logic [15:0] n[3];
    // Light above, camera above: mirror reflection, full alignment.
    write_reg(phs_pkg::CFG_LIGHT_Z, 32'h0010_0000);
    write_reg(phs_pkg::CFG_CAM_Z, 32'h0010_0000);
    p = '{32'd0, 32'd0, 32'd0};
    n = '{16'd0, 16'd0, 16'd16384};
    send_hit(p, n, 16'h8000, 16'h0A00, 1'b0);
    send_hit(p, n, 16'h8000, 16'h0000, 1'b0);
    send_hit(p, n, 16'hFFFF, 16'hFFFF, 1'b0);
    send_hit(p, n, 16'h0000, 16'h0100, 1'b0);
    // Facing away: normal pointing down.
    n = '{16'd0, 16'd0, -16'sd16384};
    send_hit(p, n, 16'h8000, 16'h0800, 1'b0);
    send_hit(p, n, 16'h8000, 16'h0000, 1'b0);
    // Point on the light and on the camera: degenerate directions.
    p = '{32'd0, 32'd0, 32'h0010_0000};
    n = '{16'h7FFF, 16'h8000, 16'hFFFF};
    send_hit(p, n, 16'h4000, 16'h0100, 1'b0);
    send_hit(p, n, 16'h4000, 16'h0000, 1'b0);
    // Extremes of the coordinates.
    p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    n = '{16'd9459, 16'd9459, 16'd9459};
    send_hit(p, n, 16'h8000, 16'h0040, 1'b0);
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    send_hit(p, n, 16'h8000, 16'h0001, 1'b0);
    // Oblique case away from alignment.
    p = '{32'h0003_0000, 32'd0, 32'd0};
    n = '{16'd0, 16'd0, 16'd16384};
    send_hit(p, n, 16'h8000, 16'h2000, 1'b0);
    send_hit(p, n, 16'h6000, 16'h0180, 1'b0);
    idle_input();
    drain();
  endtask

  task automatic test_random(int count, bit gaps);
    logic [31:0] p[3];
    logic [15:0] n[3];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 3; i++)
        case ($urandom_range(0, 3))
          0: p[i] = $urandom();
          default: p[i] = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
      rand_normal(n);
      send_hit(p, n, ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768)),
               ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 16'h2000)),
               gaps);
    end
    idle_input();
    drain();
  endtask

  task automatic config_scene(bit extreme);
    logic [31:0] v;
    for (int i = 0; i < 3; i++) begin
      v = extreme ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                  : 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      write_reg(3'(phs_pkg::CFG_CAM_X + i), v);
      v = extreme ? $urandom()
                  : 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      write_reg(3'(phs_pkg::CFG_LIGHT_X + i), v);
    end
    write_reg(phs_pkg::CFG_LIGHT_COLOR, extreme ? 32'hFFFF_FFFF : $urandom());
    write_reg(phs_pkg::CFG_LIGHT_RATIO, extreme ? 32'h0000_FFFF : $urandom_range(0, 32768));
  endtask

  // Output stall is drawn independently per result; some runs go without stalls.
  bit stall_on = 1'b1;
  initial begin
    @(posedge rst_n);
    forever begin
      int g;
      g = stall_on ? $urandom_range(0, 15) : 0;
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_expected.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %06h", rgb);
      end else begin
        logic [23:0] want;
        want = rgb_expected.pop_front();
        n_checked++;
        if (rgb !== want) begin
          n_err++;
          if (n_err <= 10) $display("spec_rgb expected %06h got %06h", want, rgb);
        end
      end
    end
  end

  initial begin
    cam_q = '{32'd0, 32'd0, 32'd0};
    lpos_q = '{32'd0, 32'd0, 32'd0};
    lcolor_q = 24'hFFFFFF;
    lratio_q = 16'h8000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    config_scene(1'b0);
    test_random(400, 1'b1);
    stall_on = 1'b0;
    test_random(200, 1'b0);
    stall_on = 1'b1;
    config_scene(1'b1);
    test_random(150, 1'b1);
    write_reg(phs_pkg::CFG_LIGHT_RATIO, 32'h0);
    test_random(50, 1'b1);
    config_scene(1'b0);
    write_reg(phs_pkg::CFG_LIGHT_COLOR, 32'h0);
    test_random(50, 1'b1);
    config_scene(1'b0);
    test_random(400, 1'b1);
    $display("Sent %0d hits over several light, camera and color settings; %0d results checked.",
             n_sent, n_checked);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/phs_pkg.sv
hw/rtl/phs_unit_dir.sv
hw/rtl/phs_pow.sv
hw/rtl/phong_specular_shade.sv
tb/tb_phong_specular_shade.sv
